>>> rtl/core/rlpl_pkg.sv
// Shared types and constants for the RLP list item splitter.
package rlpl_pkg;

	// RLP header byte boundaries
	localparam logic [7:0] SINGLE_MAX     = 8'h7f;
	localparam logic [7:0] STR_SHORT_BASE = 8'h80;
	localparam logic [7:0] STR_LONG_BASE  = 8'hb7;
	localparam logic [7:0] STR_LONG_MAX   = 8'hbf;
	localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;
	localparam logic [7:0] LIST_LONG_BASE = 8'hf7;
	localparam logic [7:0] LIST_LONG_MIN  = 8'hf8;

	localparam logic KIND_ELEM   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	typedef enum logic [3:0] {
		PH_SKIP    = 4'b0001,
		PH_LLEN    = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_TAIL    = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		IP_HDR  = 3'b001,
		IP_LEN  = 3'b010,
		IP_BODY = 3'b100
	} iphase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_HDR    = 3'd1,
		ST_TRUNC     = 3'd2,
		ST_OVERRUN   = 3'd3,
		ST_TOO_LARGE = 3'd4
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] item_byte;
		logic [3:0] item_number;
		logic       item_first;
		logic       item_last;
		status_t    status;
		logic [4:0] item_count;
	} rlpl_result_t;

	// up to two result words per input word; r1 only ever carries status
	typedef struct packed {
		logic         v0;
		rlpl_result_t r0;
		logic         v1;
		rlpl_result_t r1;
	} rlpl_push_t;

endpackage

>>> rtl/core/rlpl_if.sv
// Valid/ready channel interfaces for input bytes and result words.
interface rlpl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface rlpl_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] item_byte;
	logic [3:0] item_number;
	logic       item_first;
	logic       item_last;
	logic [2:0] status;
	logic [4:0] item_count;

	modport source(output valid, output kind, output item_byte, output item_number,
		output item_first, output item_last, output status, output item_count,
		input ready);
	modport sink(input valid, input kind, input item_byte, input item_number,
		input item_first, input item_last, input status, input item_count,
		output ready);
endinterface

>>> rtl/core/rlpl_parse.sv
// Input register and single-pass RLP list/element parser.
module rlpl_parse #(
	parameter int LEN_BITS  = 32,
	parameter int MAX_ITEMS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	rlpl_in_if.sink             in_ch,
	input  logic [7:0]          list_offset,
	input  logic                room,
	output rlpl_pkg::rlpl_push_t push
);
	import rlpl_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic                s1_v_q;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                fire;

	phase_t              phase_q, phase_d;
	logic [7:0]          skip_q, skip_d;
	logic [3:0]          llen_q, llen_d;
	logic [LEN_BITS-1:0] payload_q, payload_d;
	iphase_t             iphase_q, iphase_d;
	logic [3:0]          ilen_q, ilen_d;
	logic [LEN_BITS-1:0] item_left_q, item_left_d;
	logic [LEN_BITS-1:0] accum_q, accum_d;
	logic [CW-1:0]       items_q, items_d;
	status_t             err_q, err_d;

	logic [LEN_BITS+7:0] shift_w;
	logic [LEN_BITS-1:0] accum_sh;
	logic                ovf;
	logic [6:0]          len_short;
	logic [3:0]          len_ll;
	logic [3:0]          cnt_dec;
	logic [LEN_BITS-1:0] len_dec;
	logic                elem_v;
	logic                elem_first;
	logic                elem_last;
	logic [3:0]          elem_num;
	status_t             st;
	logic [CW-1:0]       cnt_out;
	rlpl_result_t        elem_r, stat_r;

	assign fire         = s1_v_q && room;
	assign in_ch.ready  = !s1_v_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_v_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// length byte shifted into the accumulator; overflow if top byte busy
	assign shift_w  = {accum_q, byte_s1};
	assign accum_sh = shift_w[LEN_BITS-1:0];
	assign ovf      = |accum_q[LEN_BITS-1 -: 8];
	assign elem_num = (items_q > CW'(15)) ? 4'd15 : 4'(items_q);

	always_comb begin
		phase_d     = phase_q;
		skip_d      = skip_q;
		llen_d      = llen_q;
		payload_d   = payload_q;
		iphase_d    = iphase_q;
		ilen_d      = ilen_q;
		item_left_d = item_left_q;
		accum_d     = accum_q;
		items_d     = items_q;
		err_d       = err_q;
		elem_v      = 1'b0;
		elem_first  = 1'b0;
		elem_last   = 1'b0;
		len_short   = (byte_s1 <= STR_LONG_BASE) ? 7'(byte_s1 - STR_SHORT_BASE)
		                                         : 7'(byte_s1 - LIST_SHORT_BASE);
		len_ll      = (byte_s1 <= STR_LONG_MAX) ? 4'(byte_s1 - STR_LONG_BASE)
		                                        : 4'(byte_s1 - LIST_LONG_BASE);
		cnt_dec     = 4'd0;
		len_dec     = '0;

		case (phase_q)
			PH_SKIP: begin
				if (skip_q < list_offset) begin
					skip_d = skip_q + 8'd1;
				end else if (byte_s1 >= LIST_LONG_MIN) begin
					llen_d  = 4'(byte_s1 - LIST_LONG_BASE);
					accum_d = '0;
					phase_d = PH_LLEN;
				end else if (byte_s1 >= LIST_SHORT_BASE) begin
					payload_d = LEN_BITS'(byte_s1 - LIST_SHORT_BASE);
					phase_d   = (byte_s1 != LIST_SHORT_BASE) ? PH_PAYLOAD : PH_TAIL;
				end else begin
					err_d   = ST_NO_HDR;
					phase_d = PH_TAIL;
				end
			end
			PH_LLEN: begin
				if (ovf) err_d = ST_TOO_LARGE;
				else accum_d = accum_sh;
				cnt_dec = (llen_q != 4'd0) ? llen_q - 4'd1 : 4'd0;
				llen_d  = cnt_dec;
				if (cnt_dec == 4'd0) begin
					if (err_d != ST_OK) begin
						phase_d = PH_TAIL;
					end else begin
						payload_d = accum_d;
						phase_d   = (accum_d != '0) ? PH_PAYLOAD : PH_TAIL;
					end
				end
			end
			PH_PAYLOAD: begin
				if (err_q == ST_OK) begin
					case (iphase_q)
						IP_HDR: begin
							if (byte_s1 <= SINGLE_MAX) begin
								elem_v     = 1'b1;
								elem_first = 1'b1;
								elem_last  = 1'b1;
								if (items_q < CW'(MAX_ITEMS)) items_d = items_q + CW'(1);
							end else if (byte_s1 <= STR_LONG_BASE ||
							             (byte_s1 >= LIST_SHORT_BASE &&
							              byte_s1 <= LIST_LONG_BASE)) begin
								if (LEN_BITS'(len_short) >= payload_q) begin
									err_d = ST_OVERRUN;
								end else begin
									elem_v     = 1'b1;
									elem_first = 1'b1;
									elem_last  = (len_short == 7'd0);
									if (len_short == 7'd0) begin
										if (items_q < CW'(MAX_ITEMS))
											items_d = items_q + CW'(1);
									end else begin
										item_left_d = LEN_BITS'(len_short);
										iphase_d    = IP_BODY;
									end
								end
							end else begin
								if (LEN_BITS'(len_ll) >= payload_q) begin
									err_d = ST_OVERRUN;
								end else begin
									elem_v     = 1'b1;
									elem_first = 1'b1;
									ilen_d     = len_ll;
									accum_d    = '0;
									iphase_d   = IP_LEN;
								end
							end
						end
						IP_LEN: begin
							if (ovf) begin
								err_d = ST_TOO_LARGE;
							end else begin
								accum_d = accum_sh;
								cnt_dec = (ilen_q != 4'd0) ? ilen_q - 4'd1 : 4'd0;
								ilen_d  = cnt_dec;
								if (cnt_dec != 4'd0) begin
									elem_v = 1'b1;
								end else if (accum_sh >= payload_q) begin
									err_d = ST_OVERRUN;
								end else begin
									elem_v    = 1'b1;
									elem_last = (accum_sh == '0);
									if (accum_sh == '0) begin
										if (items_q < CW'(MAX_ITEMS))
											items_d = items_q + CW'(1);
										iphase_d = IP_HDR;
									end else begin
										item_left_d = accum_sh;
										iphase_d    = IP_BODY;
									end
								end
							end
						end
						IP_BODY: begin
							len_dec     = (item_left_q != '0) ? item_left_q - LEN_BITS'(1)
							                                  : item_left_q;
							item_left_d = len_dec;
							elem_v      = 1'b1;
							elem_last   = (len_dec == '0);
							if (len_dec == '0) begin
								if (items_q < CW'(MAX_ITEMS)) items_d = items_q + CW'(1);
								iphase_d = IP_HDR;
							end
						end
						default: begin
							iphase_d = IP_HDR;
						end
					endcase
				end
				len_dec   = (payload_q != '0) ? payload_q - LEN_BITS'(1) : payload_q;
				payload_d = len_dec;
				if (len_dec == '0) phase_d = PH_TAIL;
			end
			PH_TAIL: begin
			end
			default: begin
				phase_d = PH_SKIP;
			end
		endcase

		// final status, taken before the per-buffer clear
		if (phase_d == PH_SKIP) st = ST_NO_HDR;
		else if (phase_d == PH_LLEN || phase_d == PH_PAYLOAD) st = ST_TRUNC;
		else st = err_d;
		cnt_out = items_d;

		if (last_s1) begin
			phase_d     = PH_SKIP;
			skip_d      = 8'd0;
			llen_d      = 4'd0;
			payload_d   = '0;
			iphase_d    = IP_HDR;
			ilen_d      = 4'd0;
			item_left_d = '0;
			accum_d     = '0;
			items_d     = '0;
			err_d       = ST_OK;
		end
	end

	always_comb begin
		elem_r             = '0;
		elem_r.kind        = KIND_ELEM;
		elem_r.item_byte   = byte_s1;
		elem_r.item_number = elem_num;
		elem_r.item_first  = elem_first;
		elem_r.item_last   = elem_last;
		elem_r.status      = ST_OK;

		stat_r             = '0;
		stat_r.kind        = KIND_STATUS;
		stat_r.status      = st;
		stat_r.item_count  = 5'(cnt_out);

		push.v0 = fire && (elem_v || last_s1);
		push.r0 = elem_v ? elem_r : stat_r;
		push.v1 = fire && elem_v && last_s1;
		push.r1 = stat_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			skip_q      <= 8'd0;
			llen_q      <= 4'd0;
			payload_q   <= '0;
			iphase_q    <= IP_HDR;
			ilen_q      <= 4'd0;
			item_left_q <= '0;
			accum_q     <= '0;
			items_q     <= '0;
			err_q       <= ST_OK;
		end else if (fire) begin
			phase_q     <= phase_d;
			skip_q      <= skip_d;
			llen_q      <= llen_d;
			payload_q   <= payload_d;
			iphase_q    <= iphase_d;
			ilen_q      <= ilen_d;
			item_left_q <= item_left_d;
			accum_q     <= accum_d;
			items_q     <= items_d;
			err_q       <= err_d;
		end
	end

endmodule

>>> rtl/core/rlpl_out_fifo.sv
// Small result queue: takes up to two words a cycle, drives one out.
module rlpl_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlpl_pkg::rlpl_push_t push,
	output logic                 room,
	rlpl_out_if.source           out_ch
);
	import rlpl_pkg::*;

	rlpl_result_t     mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_push;
	logic             pop;
	rlpl_result_t     rd;

	assign room   = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
	assign pop    = out_ch.valid && out_ch.ready;
	assign n_push = CNT_W'(push.v0) + CNT_W'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) mem[wr_q] <= push.r0;
		if (push.v1) mem[wr_q + PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

	assign rd                 = mem[rd_q];
	assign out_ch.valid       = cnt_q != '0;
	assign out_ch.kind        = rd.kind;
	assign out_ch.item_byte   = rd.item_byte;
	assign out_ch.item_number = rd.item_number;
	assign out_ch.item_first  = rd.item_first;
	assign out_ch.item_last   = rd.item_last;
	assign out_ch.status      = rd.status;
	assign out_ch.item_count  = rd.item_count;

endmodule

>>> rtl/core/rlp_list_item_splitter_unit.sv
// An input word is held in the input register, then written into the result queue, which drives it out.
// Throughput: one input word per cycle while the result queue has room; parser state updates once per word.
// A last word that also carries an element byte gives two result words, driven out one at a time;
// the 4-entry result queue absorbs that, input stalls only while it holds more than two.
// Reset (arst_n low, async): parser to prefix skip, queue emptied, list_offset to 0.
module rlp_list_item_splitter_unit #(
	parameter int LEN_BITS  = 32,
	parameter int MAX_ITEMS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	rlpl_in_if.sink    in_ch,
	rlpl_out_if.source out_ch
);
	import rlpl_pkg::*;

	// number of leading buffer bytes to skip before the list header
	logic [7:0] list_offset_q;

	// parser -> queue: element word and/or status word for one input word
	rlpl_push_t push;
	logic       room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_offset_q <= 8'd0;
		end else if (cfg_wr_en) begin
			list_offset_q <= cfg_wr_data;
		end
	end

	// Input register plus header/length/body walk. Fires only when the
	// queue has space for two words, so a status never gets dropped.
	rlpl_parse #(
		.LEN_BITS  (LEN_BITS),
		.MAX_ITEMS (MAX_ITEMS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.list_offset (list_offset_q),
		.room        (room),
		.push        (push)
	);

	// Result queue decouples the parser from output back-pressure.
	rlpl_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule

>>> verif/tb.sv
// Self-checking testbench for the RLP list item splitter unit.
`timescale 1ns / 1ps

module tb;
	import rlpl_pkg::*;

	localparam int LEN_BITS     = 32;
	localparam int MAX_ITEMS    = 16;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 11;
	// Result queue plus pipeline is well under this; used before config writes and at the end.
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	rlpl_in_if  in_ch();
	rlpl_out_if out_ch();

	rlp_list_item_splitter_unit #(
		.LEN_BITS (LEN_BITS),
		.MAX_ITEMS(MAX_ITEMS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	// ------------------------------------------------------------------
	// Parser mirror: tracks the block's state word by word and queues the
	// result words each accepted input word should produce.
	// ------------------------------------------------------------------
	logic [7:0]   m_offset;
	phase_t       m_phase;
	logic [7:0]   m_skipped;        // prefix bytes skipped so far
	logic [3:0]   m_llen_left;      // list length bytes still to come
	logic [63:0]  m_payload_left;
	iphase_t      m_iphase;
	logic [3:0]   m_ilen_left;      // element length bytes still to come
	logic [63:0]  m_item_left;
	logic [63:0]  m_accum;          // big-endian length being assembled
	logic [4:0]   m_count;          // complete elements, saturating
	status_t      m_err;

	rlpl_result_t words_due[$];

	// TB bookkeeping
	int unsigned  cycle_count;
	int unsigned  err_count;
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	bit           hold_toggle;      // flipped by a test to request a long receiver stall
	bit           hold_seen;
	int unsigned  hold_left;
	logic [7:0]   cur_offset;       // offset the frame builder prefixes with
	logic [7:0]   raw_bytes[$];     // frame being sent
	logic [7:0]   body_bytes[$];    // list payload while a frame is built
	rlpl_result_t due_word;

	function automatic void reset_parser();
		m_phase        = PH_SKIP;
		m_skipped      = '0;
		m_llen_left    = '0;
		m_payload_left = '0;
		m_iphase       = IP_HDR;
		m_ilen_left    = '0;
		m_item_left    = '0;
		m_accum        = '0;
		m_count        = '0;
		m_err          = ST_OK;
	endfunction

	// Shift in one length byte; 1 means the value no longer fits LEN_BITS.
	function automatic bit shift_len_byte(logic [7:0] b);
		if ((m_accum >> (LEN_BITS - 8)) != 0)
			return 1'b1;
		m_accum = {m_accum[55:0], b};
		return 1'b0;
	endfunction

	function automatic void bump_count();
		if (m_count < MAX_ITEMS)
			m_count++;
	endfunction

	function automatic void push_item_byte(logic [7:0] b, logic first, logic last);
		rlpl_result_t r;
		r             = '0;
		r.kind        = KIND_ELEM;
		r.item_byte   = b;
		r.item_number = (m_count > 15) ? 4'd15 : m_count[3:0];
		r.item_first  = first;
		r.item_last   = last;
		r.status      = ST_OK;
		words_due     = {words_due, r};
	endfunction

	// One payload byte, no error latched yet.
	function automatic void walk_element(logic [7:0] b);
		logic [63:0] len;
		logic [3:0]  ll;
		case (m_iphase)
			IP_HDR: begin
				if (b <= SINGLE_MAX) begin
					push_item_byte(b, 1'b1, 1'b1);
					bump_count();
				end else if (b <= STR_LONG_BASE || (b >= LIST_SHORT_BASE && b <= LIST_LONG_BASE)) begin
					len = (b <= STR_LONG_BASE) ? 64'(b - STR_SHORT_BASE)
					                           : 64'(b - LIST_SHORT_BASE);
					if (len + 1 > m_payload_left) begin
						m_err = ST_OVERRUN;
					end else begin
						push_item_byte(b, 1'b1, len == 0);
						if (len == 0) begin
							bump_count();
						end else begin
							m_item_left = len;
							m_iphase    = IP_BODY;
						end
					end
				end else begin
					ll = (b <= STR_LONG_MAX) ? 4'(b - STR_LONG_BASE) : 4'(b - LIST_LONG_BASE);
					if (64'(ll) + 1 > m_payload_left) begin
						m_err = ST_OVERRUN;
					end else begin
						push_item_byte(b, 1'b1, 1'b0);
						m_ilen_left = ll;
						m_accum     = '0;
						m_iphase    = IP_LEN;
					end
				end
			end
			IP_LEN: begin
				if (shift_len_byte(b)) begin
					m_err = ST_TOO_LARGE;
				end else begin
					if (m_ilen_left != 0)
						m_ilen_left--;
					if (m_ilen_left != 0) begin
						push_item_byte(b, 1'b0, 1'b0);
					end else if (m_accum > m_payload_left - 1) begin
						m_err = ST_OVERRUN;
					end else begin
						push_item_byte(b, 1'b0, m_accum == 0);
						if (m_accum == 0) begin
							bump_count();
							m_iphase = IP_HDR;
						end else begin
							m_item_left = m_accum;
							m_iphase    = IP_BODY;
						end
					end
				end
			end
			default: begin
				if (m_item_left != 0)
					m_item_left--;
				push_item_byte(b, 1'b0, m_item_left == 0);
				if (m_item_left == 0) begin
					bump_count();
					m_iphase = IP_HDR;
				end
			end
		endcase
	endfunction

	// Called once per accepted input word.
	function automatic void advance_parser(logic [7:0] b, logic last);
		rlpl_result_t r;
		case (m_phase)
			PH_SKIP: begin
				if (m_skipped < m_offset) begin
					m_skipped++;
				end else if (b >= LIST_LONG_MIN) begin
					m_llen_left = 4'(b - LIST_LONG_BASE);
					m_accum     = '0;
					m_phase     = PH_LLEN;
				end else if (b >= LIST_SHORT_BASE) begin
					m_payload_left = 64'(b - LIST_SHORT_BASE);
					m_phase        = (m_payload_left != 0) ? PH_PAYLOAD : PH_TAIL;
				end else begin
					m_err   = ST_NO_HDR;
					m_phase = PH_TAIL;
				end
			end
			PH_LLEN: begin
				// once too large, the accumulator stops moving but bytes still count down
				if (shift_len_byte(b))
					m_err = ST_TOO_LARGE;
				if (m_llen_left != 0)
					m_llen_left--;
				if (m_llen_left == 0) begin
					if (m_err != ST_OK) begin
						m_phase = PH_TAIL;
					end else begin
						m_payload_left = m_accum;
						m_phase        = (m_payload_left != 0) ? PH_PAYLOAD : PH_TAIL;
					end
				end
			end
			PH_PAYLOAD: begin
				if (m_err == ST_OK)
					walk_element(b);
				if (m_payload_left != 0)
					m_payload_left--;
				if (m_payload_left == 0)
					m_phase = PH_TAIL;
			end
			default: ;  // trailing bytes ignored
		endcase

		if (last) begin
			r            = '0;
			r.kind       = KIND_STATUS;
			// truncation beats any latched element error
			if (m_phase == PH_SKIP)
				r.status = ST_NO_HDR;
			else if (m_phase == PH_LLEN || m_phase == PH_PAYLOAD)
				r.status = ST_TRUNC;
			else
				r.status = m_err;
			r.item_count = m_count;
			words_due    = {words_due, r};
			reset_parser();
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock, cycle count and watchdog
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk)
		cycle_count++;

	initial begin
		wait (cycle_count > CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random ready, with an optional long stall on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_seen != hold_toggle) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted result word against the oldest due
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		err_count++;
		$display("mismatch @cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (words_due.size() == 0) begin
				report_mismatch("result word with nothing due");
			end else begin
				due_word = words_due.pop_front();
				check_field("kind",        8'(out_ch.kind),        8'(due_word.kind));
				check_field("item_byte",   out_ch.item_byte,       due_word.item_byte);
				check_field("item_number", 8'(out_ch.item_number), 8'(due_word.item_number));
				check_field("item_first",  8'(out_ch.item_first),  8'(due_word.item_first));
				check_field("item_last",   8'(out_ch.item_last),   8'(due_word.item_last));
				check_field("status",      8'(out_ch.status),      8'(due_word.status));
				check_field("item_count",  8'(out_ch.item_count),  8'(due_word.item_count));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender. Entered and left at a falling edge; valid stays high on exit
	// so back-to-back words need no second assignment in one step.
	// ------------------------------------------------------------------
	task automatic send_word(input logic [7:0] b, input logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		advance_parser(b, last);
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (raw_bytes[i])
			send_word(raw_bytes[i], i == raw_bytes.size() - 1);
	endtask

	// Drop valid, wait for every due word, then let the pipeline settle.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (words_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Config writes only with the block idle.
	task automatic write_offset(input logic [7:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		m_offset    = v;
		cur_offset  = v;
	endtask

	// ------------------------------------------------------------------
	// Frame builder
	// ------------------------------------------------------------------
	function automatic logic [7:0] len_byte(logic [63:0] v, int i);
		return 8'(v >> (8 * i));
	endfunction

	function automatic int unsigned need_bytes(logic [63:0] v);
		int unsigned n;
		n = 1;
		while ((v >> (8 * n)) != 0)
			n++;
		return n;
	endfunction

	function automatic void add_body_byte(int unsigned v);
		body_bytes = {body_bytes, 8'(v)};
	endfunction

	function automatic void add_raw_byte(int unsigned v);
		raw_bytes = {raw_bytes, 8'(v)};
	endfunction

	// Append one element encoding to the payload; oversize gives a length
	// that cannot fit LEN_BITS.
	function automatic void add_element(bit oversize);
		int unsigned pick;
		int unsigned len;
		int unsigned ll;
		logic [7:0]  base;
		pick = $urandom_range(99);
		if (oversize) begin
			ll = $urandom_range(5, 8);
			add_body_byte(STR_LONG_BASE + ll);
			add_body_byte($urandom_range(1, 255));
			repeat (ll - 1) add_body_byte($urandom_range(255));
			return;
		end
		if (pick < 30) begin
			add_body_byte($urandom_range(127));
			return;
		end
		len = ($urandom_range(9) == 0) ? $urandom_range(55) : $urandom_range(6);
		if (pick < 65) begin
			base = $urandom_range(1) ? STR_SHORT_BASE : LIST_SHORT_BASE;
			add_body_byte(base + len);
		end else begin
			// long form; short lengths here are legal to the parser, leading zeros too
			if ($urandom_range(7) == 0)
				len = $urandom_range(56, 200);
			ll = need_bytes(64'(len));
			ll = ($urandom_range(9) == 0) ? $urandom_range(ll, 8) : ll + $urandom_range(1);
			base = $urandom_range(1) ? STR_LONG_BASE : LIST_LONG_BASE;
			add_body_byte(base + ll);
			for (int i = ll - 1; i >= 0; i--)
				body_bytes = {body_bytes, len_byte(64'(len), i)};
		end
		repeat (len) add_body_byte($urandom_range(255));
	endfunction

	// Mostly well-formed lists with random content; the rest noise or broken.
	function automatic void build_frame();
		int unsigned mode;
		int unsigned n_elem;
		int unsigned plen;
		int unsigned ll;
		int unsigned cut;
		raw_bytes.delete();
		body_bytes.delete();
		mode = $urandom_range(99);
		repeat (cur_offset) add_raw_byte($urandom_range(255));
		if (mode < 5) begin
			repeat ($urandom_range(1, 16)) add_raw_byte($urandom_range(255));
			return;
		end
		if (mode < 10) begin
			// not a list header
			add_raw_byte($urandom_range(8'hbf));
			repeat ($urandom_range(4)) add_raw_byte($urandom_range(255));
			return;
		end
		if (mode < 14) begin
			// list length beyond LEN_BITS
			ll = $urandom_range(5, 8);
			add_raw_byte(LIST_LONG_BASE + ll);
			add_raw_byte($urandom_range(1, 255));
			repeat (ll - 1 + $urandom_range(3)) add_raw_byte($urandom_range(255));
			return;
		end
		// occasionally enough elements to saturate the count
		n_elem = ($urandom_range(11) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
		for (int i = 0; i < n_elem; i++)
			add_element(mode < 19 && i == n_elem - 1);
		plen = body_bytes.size();
		// list header claims less than the elements need: element overrun
		if (mode >= 19 && mode < 26 && plen > 1)
			plen -= $urandom_range(1, (plen > 3) ? 3 : plen - 1);
		if (plen <= 55 && $urandom_range(3) != 0) begin
			add_raw_byte(LIST_SHORT_BASE + plen);
		end else begin
			ll = need_bytes(64'(plen)) + $urandom_range(1);
			add_raw_byte(LIST_LONG_BASE + ll);
			for (int i = ll - 1; i >= 0; i--)
				raw_bytes = {raw_bytes, len_byte(64'(plen), i)};
		end
		raw_bytes = {raw_bytes, body_bytes};
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 4)) add_raw_byte($urandom_range(255));
		// cut short: truncated list
		if (mode >= 26 && mode < 34 && raw_bytes.size() > 1) begin
			cut = $urandom_range(1, raw_bytes.size() - 1);
			raw_bytes = raw_bytes[0:cut-1];
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		raw_bytes = '{8'h05};                                     // no list header
		send_frame();
		raw_bytes = '{8'hc0, 8'hee};                              // empty list, tail ignored
		send_frame();
		raw_bytes = '{8'hc3, 8'h00, 8'h80, 8'h7f};                // two singles, empty string
		send_frame();
		raw_bytes = '{8'hc3, 8'hb8, 8'h01, 8'hff};                // long-form string
		send_frame();
		raw_bytes = '{8'hc2, 8'h82, 8'hff};                       // element overruns list
		send_frame();
		raw_bytes = '{8'hf8, 8'h05, 8'hc1};                       // ends inside payload
		send_frame();
		raw_bytes = '{8'hf9, 8'h00};                              // ends inside list length
		send_frame();
		raw_bytes = '{8'hc6, 8'hbc, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}; // element too large
		send_frame();
	endtask

	task automatic test_offsets();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_offset(8'd255);
		raw_bytes.delete();
		repeat (20) add_raw_byte($urandom_range(255));            // ends inside the prefix
		send_frame();
		build_frame();
		send_frame();
		write_offset(8'd1);
		repeat (2) begin
			build_frame();
			send_frame();
		end
		write_offset(8'd0);
	endtask

	task automatic test_random(input int unsigned snd_pct, input int unsigned rcv_pct,
			input int unsigned n_words);
		int unsigned sent;
		sent = 0;
		write_offset(8'($urandom_range(3)));
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		while (sent < n_words) begin
			build_frame();
			send_frame();
			sent += raw_bytes.size();
		end
	endtask

	// Long receiver stall while the sender keeps offering a long list of
	// single-byte elements: the result queue fills and input must stall.
	task automatic test_backpressure();
		write_offset(8'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_toggle   = ~hold_toggle;
		raw_bytes.delete();
		add_raw_byte(LIST_SHORT_BASE + 50);
		repeat (50) add_raw_byte($urandom_range(127));
		send_frame();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready    = 1'b0;
		cycle_count     = 0;
		err_count       = 0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_toggle     = 1'b0;
		hold_seen       = 1'b0;
		hold_left       = 0;
		m_offset        = '0;
		cur_offset      = '0;
		reset_parser();

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_offsets();
		test_random(10, 57, 400);
		test_random(57, 10, 380);
		test_random(0, 0, 380);
		test_backpressure();

		wait_drained();
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> rlp_list_item_splitter_unit.f
rtl/core/rlpl_pkg.sv
rtl/core/rlpl_if.sv
rtl/core/rlpl_parse.sv
rtl/core/rlpl_out_fifo.sv
rtl/core/rlp_list_item_splitter_unit.sv
verif/tb.sv
